FILE: design/debug_packet_deframer_macros.svh
// ----------------------------------------------------------------------------
// Debug packet deframer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEBUG_PACKET_DEFRAMER_MACROS_SVH
`define DEBUG_PACKET_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dpd_pkg.sv
// ----------------------------------------------------------------------------
// Debug packet deframer package
// Framing characters, result kinds and the result record shared by the modules.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam logic [7:0] CH_START        = 8'h24;
  localparam logic [7:0] CH_END          = 8'h23;
  localparam logic [7:0] CH_ESC          = 8'h7D;
  localparam logic [7:0] ESC_MASK_RESET  = 8'h20;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
  } result_t;

endpackage

FILE: design/debug_packet_deframer.sv
// ----------------------------------------------------------------------------
// Debug packet deframer
// Splits a serial debug byte stream into payload bytes and packet status.
// ----------------------------------------------------------------------------
// One received byte is accepted per clock cycle. The only pause comes from the
// output register: while it holds a result that m_axis_tready has not taken,
// s_axis_tready is low. The result of a byte appears on the master side in the
// cycle after the byte's transaction. The framing state, running sum and
// checksum digit are all updated as each byte is accepted, so bytes may follow
// each other without gaps. The escape mask may be written at any idle moment;
// the configuration channel is always ready.
module debug_packet_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_wdata_i     // [7:0] escape_mask
);

  logic             in_fire;
  logic             res_valid;
  logic             space;
  dpd_pkg::result_t res;
  dpd_pkg::result_t out_res;

  assign s_axis_tready = space;
  assign in_fire       = s_axis_tvalid && space;
  assign cfg_ready_o   = 1'b1;

  dpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .rx_byte_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_wdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out_res),
    .space_o     (space)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tuser = out_res.kind;

endmodule

FILE: design/dpd_core.sv
// ----------------------------------------------------------------------------
// Debug packet deframer core
// Holds the framing state and decides the result of each accepted byte.
// ----------------------------------------------------------------------------
`include "debug_packet_deframer_macros.svh"

module dpd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  output logic             res_valid_o,
  output dpd_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_DATA = 3'd1,
    PH_ESCD = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [3:0] nibble_q, nibble_d;
  logic [7:0] mask_q;
  logic [7:0] sum_plus;
  logic       hex_ok;
  logic [3:0] hex_val;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  assign sum_plus          = sum_q + rx_byte_i;
  assign {hex_ok, hex_val} = hex_decode(rx_byte_i);

  always_comb begin
    phase_d      = phase_q;
    sum_d        = sum_q;
    nibble_d     = nibble_q;
    res_valid_o  = 1'b0;
    res_o.kind   = dpd_pkg::KIND_BAD;
    res_o.data   = sum_q;
    if (in_fire_i) begin
      unique case (phase_q)
        PH_DATA: begin
          if (rx_byte_i == dpd_pkg::CH_START) begin
            phase_d     = PH_HUNT;
            res_valid_o = 1'b1;
          end else if (rx_byte_i == dpd_pkg::CH_END) begin
            phase_d = PH_HEX1;
          end else begin
            sum_d = sum_plus;
            if (rx_byte_i == dpd_pkg::CH_ESC) begin
              phase_d = PH_ESCD;
            end else begin
              res_valid_o = 1'b1;
              res_o.kind  = dpd_pkg::KIND_DATA;
              res_o.data  = rx_byte_i;
            end
          end
        end
        PH_ESCD: begin
          sum_d       = sum_plus;
          phase_d     = PH_DATA;
          res_valid_o = 1'b1;
          res_o.kind  = dpd_pkg::KIND_DATA;
          res_o.data  = rx_byte_i ^ mask_q;
        end
        PH_HEX1: begin
          if (hex_ok) begin
            nibble_d = hex_val;
            phase_d  = PH_HEX2;
          end else begin
            phase_d     = PH_HUNT;
            res_valid_o = 1'b1;
          end
        end
        PH_HEX2: begin
          phase_d     = PH_HUNT;
          res_valid_o = 1'b1;
          if (hex_ok && {nibble_q, hex_val} == sum_q) begin
            res_o.kind = dpd_pkg::KIND_GOOD;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == dpd_pkg::CH_START) begin
            sum_d   = 8'd0;
            phase_d = PH_DATA;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      sum_q    <= 8'd0;
      nibble_q <= 4'd0;
      mask_q   <= dpd_pkg::ESC_MASK_RESET;
    end else begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      nibble_q <= nibble_d;
      if (cfg_we_i) begin
        mask_q <= cfg_data_i;
      end
    end
  end

  `DPD_ASSERT_SAME(a_result_needs_byte, res_valid_o, in_fire_i, "Result without an accepted byte.")
  `DPD_ASSERT_NEXT(a_hunt_drops, in_fire_i && phase_q == PH_HUNT && rx_byte_i != dpd_pkg::CH_START, phase_q == PH_HUNT, "Hunting left without a start character.")
  `DPD_ASSERT_NEXT(a_end_returns_hunt, res_valid_o && res_o.kind != dpd_pkg::KIND_DATA, phase_q == PH_HUNT && $stable(sum_q), "Packet end did not return to hunting.")

endmodule

FILE: design/dpd_out_stage.sv
// ----------------------------------------------------------------------------
// Debug packet deframer output stage
// Result register that holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module dpd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  dpd_pkg::result_t res_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output dpd_pkg::result_t out_o,
  output logic             space_o
);

  logic             valid_q;
  dpd_pkg::result_t res_q;

  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Debug packet deframer testbench
// Drives framed and malformed byte streams with random gaps and stalls, and
// checks every result transaction against a cycle-free model of the framer.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned STALL_CYCLES = 200;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_DATA,
    PH_ESCAPED,
    PH_HEX_HI,
    PH_HEX_LO
  } frame_phase_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_wdata_i = 8'h00;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  logic         stall_on = 1'b0;
  event         stall_begin;

  logic [7:0]       model_mask = dpd_pkg::ESC_MASK_RESET;
  frame_phase_e     model_phase = PH_HUNT;
  logic [7:0]       model_sum = 8'h00;
  logic [3:0]       model_high = 4'h0;
  dpd_pkg::result_t expected_results[$];

  debug_packet_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always begin
    @(stall_begin);
    stall_on = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    stall_on = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !stall_on && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    return 5'h00;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] h;
    do begin
      c = 8'($urandom);
      h = hex_digit(c);
    end while (h[4]);
    return c;
  endfunction

  function void deframe_byte(input logic [7:0] b);
    logic [4:0] h;
    unique case (model_phase)
      PH_DATA: begin
        if (b == dpd_pkg::CH_START) begin
          model_phase = PH_HUNT;
          expected_results.push_back('{dpd_pkg::KIND_BAD, model_sum});
        end else if (b == dpd_pkg::CH_END) begin
          model_phase = PH_HEX_HI;
        end else begin
          model_sum = model_sum + b;
          if (b == dpd_pkg::CH_ESC) model_phase = PH_ESCAPED;
          else expected_results.push_back('{dpd_pkg::KIND_DATA, b});
        end
      end
      PH_ESCAPED: begin
        model_sum = model_sum + b;
        model_phase = PH_DATA;
        expected_results.push_back('{dpd_pkg::KIND_DATA, b ^ model_mask});
      end
      PH_HEX_HI: begin
        h = hex_digit(b);
        if (!h[4]) begin
          model_phase = PH_HUNT;
          expected_results.push_back('{dpd_pkg::KIND_BAD, model_sum});
        end else begin
          model_high = h[3:0];
          model_phase = PH_HEX_LO;
        end
      end
      PH_HEX_LO: begin
        h = hex_digit(b);
        model_phase = PH_HUNT;
        if (h[4] && {model_high, h[3:0]} == model_sum)
          expected_results.push_back('{dpd_pkg::KIND_GOOD, model_sum});
        else
          expected_results.push_back('{dpd_pkg::KIND_BAD, model_sum});
      end
      default: begin
        model_phase = PH_HUNT;
        if (b == dpd_pkg::CH_START) begin
          model_sum = 8'h00;
          model_phase = PH_DATA;
        end
      end
    endcase
  endfunction

  always @(posedge clk_i) begin : check_result
    dpd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d data %02h",
                 $time, m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $display("%0t: kind mismatch, expected %0d, actual %0d",
                   $time, want.kind, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata !== want.data) begin
          $display("%0t: data mismatch, expected %02h, actual %02h",
                   $time, want.data, m_axis_tdata);
          error_count++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_escape_mask(input logic [7:0] mask);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= mask;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_mask = mask;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_wdata_i <= 8'($urandom);
  endtask

  // Mostly well-formed packets; the rest break at each point of the frame.
  task automatic send_random_frame();
    int unsigned shape;
    logic [7:0]  b;
    logic [7:0]  sum;
    shape = $urandom_range(99);
    sum = 8'h00;
    repeat ($urandom_range(2)) begin
      b = 8'($urandom);
      if (b == dpd_pkg::CH_START) b = 8'h00;
      send_byte(b);
    end
    if (shape >= 96) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      return;
    end
    send_byte(dpd_pkg::CH_START);
    repeat ($urandom_range(0, 10)) begin
      if ($urandom_range(99) < 15) begin
        b = 8'($urandom);
        send_byte(dpd_pkg::CH_ESC);
        send_byte(b);
        sum = sum + dpd_pkg::CH_ESC + b;
      end else begin
        b = 8'($urandom);
        if (b == dpd_pkg::CH_START || b == dpd_pkg::CH_END || b == dpd_pkg::CH_ESC)
          b = b ^ 8'h40;
        send_byte(b);
        sum = sum + b;
      end
    end
    if (shape >= 91) begin
      send_byte(dpd_pkg::CH_START);
      return;
    end
    send_byte(dpd_pkg::CH_END);
    if (shape >= 77 && shape < 85) begin
      send_byte(non_hex_char());
      return;
    end
    if (shape >= 65 && shape < 77) sum = sum + 8'($urandom_range(1, 255));
    send_byte(hex_char(sum[7:4]));
    if (shape >= 85) send_byte(non_hex_char());
    else send_byte(hex_char(sum[3:0]));
  endtask

  task automatic run_random_frames(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_frame();
  endtask

  task automatic test_hunting_noise();
    send_byte(8'h00); send_byte(8'hFF);
    send_byte(dpd_pkg::CH_END); send_byte(dpd_pkg::CH_ESC);
  endtask

  task automatic test_escaped_specials();
    send_byte(dpd_pkg::CH_START); send_byte(8'h00); send_byte(8'hFF);
    send_byte(dpd_pkg::CH_ESC); send_byte(dpd_pkg::CH_START);
    send_byte(dpd_pkg::CH_ESC); send_byte(dpd_pkg::CH_ESC);
    send_byte(dpd_pkg::CH_END); send_byte(8'h39); send_byte(8'h61);
  endtask

  task automatic test_start_in_payload();
    send_byte(dpd_pkg::CH_START); send_byte(8'h41); send_byte(dpd_pkg::CH_START);
  endtask

  task automatic test_checksum_errors();
    send_byte(dpd_pkg::CH_START); send_byte(dpd_pkg::CH_END); send_byte(8'h67);
    send_byte(dpd_pkg::CH_START); send_byte(dpd_pkg::CH_END);
    send_byte(8'h30); send_byte(8'h2F);
    send_byte(dpd_pkg::CH_START); send_byte(dpd_pkg::CH_END);
    send_byte(8'h46); send_byte(8'h30);
  endtask

  task automatic test_random_slow_receiver();
    send_idle_pct = 27;
    recv_idle_pct = 74;
    write_escape_mask(8'hFF);
    run_random_frames(480);
  endtask

  task automatic test_random_slow_sender();
    send_idle_pct = 74;
    recv_idle_pct = 27;
    write_escape_mask(8'h00);
    run_random_frames(480);
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_escape_mask(8'($urandom));
    run_random_frames(440);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_escape_mask(8'($urandom));
    -> stall_begin;
    run_random_frames(60);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 74;
    test_hunting_noise();
    test_escaped_specials();
    test_start_in_payload();
    test_checksum_errors();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();
    test_output_backpressure();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
